FILE: hw/rtl/bvpe_pkg.sv
// ----------------------------------------------------------------------------
// bvpe_pkg
// Shared types, constants and helpers for the Bezier volume point evaluator.
// ----------------------------------------------------------------------------
package bvpe_pkg;

    localparam int MAX_DEGREE_DEF  = 3;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int DEG_W   = 2;    // degree register width
    localparam int IDX_W   = 6;    // control point slot i*16+j*4+k
    localparam int DEPTH   = 64;
    localparam int PARAM_W = 16;   // Q1.15 parameter
    localparam int XY_W    = 32;   // coordinate port width
    localparam int WGT_W   = 31;   // Q.30 weight, up to and including 1.0
    localparam int RAW_W   = 46;   // unnormalized Bernstein product
    localparam int ACC_W   = 72;   // exact accumulator

    localparam logic [PARAM_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EVAL = 1'b1;

    localparam logic [1:0] REG_DEG_U = 2'd0;
    localparam logic [1:0] REG_DEG_V = 2'd1;
    localparam logic [1:0] REG_DEG_W = 2'd2;

    typedef struct packed {
        logic [DEG_W-1:0] nu;
        logic [DEG_W-1:0] nv;
        logic [DEG_W-1:0] nw;
    } deg_t;

    // C(n,i) for n, i up to 3
    function automatic logic [1:0] binom(input logic [DEG_W-1:0] n, input logic [DEG_W-1:0] i);
        logic [1:0] c;
        c = 2'd1;
        if (i > n)
        begin
            c = 2'd0;
        end
        else if (n == 2'd2 && i == 2'd1)
        begin
            c = 2'd2;
        end
        else if (n == 2'd3 && (i == 2'd1 || i == 2'd2))
        begin
            c = 2'd3;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/bvpe_store.sv
// ----------------------------------------------------------------------------
// bvpe_store
// Control point memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bvpe_store #(
    parameter int EFF_W = 32
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [bvpe_pkg::IDX_W-1:0] wr_addr,
    input  logic [3*EFF_W-1:0]         wr_data,
    input  logic [bvpe_pkg::IDX_W-1:0] rd_addr,
    output logic [3*EFF_W-1:0]         rd_data
);
    import bvpe_pkg::*;

    logic [3*EFF_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/bvpe_weight.sv
// ----------------------------------------------------------------------------
// bvpe_weight
// Bernstein weight sequencer: one multiply per cycle per weight factor.
// ----------------------------------------------------------------------------
module bvpe_weight #(
    parameter int MAX_DEGREE = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  bvpe_pkg::deg_t                        deg,
    input  logic [2:0][bvpe_pkg::PARAM_W-1:0]     param,
    output logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] wu,
    output logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] wv,
    output logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] ww,
    output logic                                  done
);
    import bvpe_pkg::*;

    localparam int DW = MAX_DEGREE + 1;
    localparam int IW = (DW > 1) ? $clog2(DW) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [1:0]       ax_reg, ax_next;
    logic [DEG_W-1:0] wi_reg, wi_next;
    logic [DEG_W-1:0] we_reg, we_next;
    logic [RAW_W-1:0] r_reg, r_next;
    logic [DW-1:0][WGT_W-1:0] wu_reg, wv_reg, ww_reg;

    logic [DEG_W-1:0]   n_cur, n_nxt;
    logic [PARAM_W-1:0] t_cur, s_cur, mul_op;
    logic [RAW_W+PARAM_W-1:0] prod;
    logic [WGT_W-1:0]   w_norm;
    logic               last_w;

    function automatic logic [DEG_W-1:0] pick(input deg_t d, input logic [1:0] a);
        logic [DEG_W-1:0] n;
        case (a)
            2'd0:    n = d.nu;
            2'd1:    n = d.nv;
            default: n = d.nw;
        endcase
        return n;
    endfunction

    function automatic logic [WGT_W-1:0] norm(input logic [RAW_W-1:0] r,
                                              input logic [DEG_W-1:0] n);
        logic [RAW_W-1:0] s;
        logic [WGT_W-1:0] w;
        s = r + RAW_W'(1 << 14);
        case (n)
            2'd3:    w = s[45:15];
            2'd2:    w = r[WGT_W-1:0];
            2'd1:    w = {r[15:0], 15'd0};
            default: w = {r[0], 30'd0};
        endcase
        return w;
    endfunction

    always_comb
    begin
        n_cur  = pick(deg, ax_reg);
        t_cur  = param[ax_reg];
        s_cur  = ONE_Q15 - t_cur;
        mul_op = (we_reg < wi_reg) ? t_cur : s_cur;
        prod   = r_reg * mul_op;
        w_norm = norm(r_reg, n_cur);
        last_w = (wi_reg == n_cur);
        n_nxt  = pick(deg, ax_reg + 2'd1);

        busy_next = busy_reg;
        done_next = 1'b0;
        ax_next   = ax_reg;
        wi_next   = wi_reg;
        we_next   = we_reg;
        r_next    = r_reg;

        if (start)
        begin
            busy_next = 1'b1;
            ax_next   = 2'd0;
            wi_next   = '0;
            we_next   = '0;
            r_next    = RAW_W'(binom(deg.nu, 2'd0));
        end
        else if (busy_reg)
        begin
            if (we_reg != n_cur)
            begin
                r_next  = prod[RAW_W-1:0];
                we_next = we_reg + 2'd1;
            end
            else
            begin
                we_next = '0;
                if (last_w)
                begin
                    wi_next = '0;
                    if (ax_reg == 2'd2)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                        r_next  = RAW_W'(binom(n_nxt, 2'd0));
                    end
                end
                else
                begin
                    wi_next = wi_reg + 2'd1;
                    r_next  = RAW_W'(binom(n_cur, wi_reg + 2'd1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next;
        wi_reg <= wi_next;
        we_reg <= we_next;
        r_reg  <= r_next;
        if (busy_reg && !start && we_reg == n_cur)
        begin
            case (ax_reg)
                2'd0:    wu_reg[wi_reg[IW-1:0]] <= w_norm;
                2'd1:    wv_reg[wi_reg[IW-1:0]] <= w_norm;
                default: ww_reg[wi_reg[IW-1:0]] <= w_norm;
            endcase
        end
    end

    assign wu   = wu_reg;
    assign wv   = wv_reg;
    assign ww   = ww_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/bvpe_mac.sv
// ----------------------------------------------------------------------------
// bvpe_mac
// Term loop: reads one control point per cycle, weights it, accumulates,
// then rounds and clamps the three sums.
// ----------------------------------------------------------------------------
module bvpe_mac #(
    parameter int MAX_DEGREE = 3,
    parameter int EFF_W      = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  bvpe_pkg::deg_t                           deg,
    input  logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] wu,
    input  logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] wv,
    input  logic [MAX_DEGREE:0][bvpe_pkg::WGT_W-1:0] ww,
    output logic [bvpe_pkg::IDX_W-1:0]               rd_addr,
    input  logic [3*EFF_W-1:0]                       rd_data,
    output logic [2:0][bvpe_pkg::XY_W-1:0]           res,
    output logic                                     res_sat,
    output logic                                     done
);
    import bvpe_pkg::*;

    localparam int DW  = MAX_DEGREE + 1;
    localparam int IW  = (DW > 1) ? $clog2(DW) : 1;
    localparam int PW  = EFF_W + WGT_W + 1;
    localparam int QW  = ACC_W - 30;

    localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (EFF_W - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

    logic             run_reg, iss_reg, v1_reg, v2_reg, v3_reg, done_reg;
    logic [DEG_W-1:0] ci_reg, cj_reg, ck_reg, kk1_reg;
    logic [WGT_W-1:0] wij_reg, w_reg;
    logic [2:0][EFF_W-1:0]  c2_reg;
    logic [2:0][PW-1:0]     prod_reg;
    logic [2:0][ACC_W-1:0]  acc_reg;
    logic [2:0][XY_W-1:0]   res_reg;
    logic                   sat_reg;

    logic [2*WGT_W-1:0] pij, pw;
    logic [2:0]         sat_c;
    logic [2:0][XY_W-1:0] q_c;
    logic               drained;

    function automatic logic [XY_W-1:0] finish(input logic [ACC_W-1:0] a, output logic s);
        logic signed [ACC_W-1:0] r;
        logic signed [QW-1:0]    q;
        r = $signed(a) + $signed(ACC_W'(1 << 29));
        q = QW'(r >>> 30);
        s = 1'b0;
        if (q > Q_HI)
        begin
            q = Q_HI;
            s = 1'b1;
        end
        if (q < Q_LO)
        begin
            q = Q_LO;
            s = 1'b1;
        end
        return q[XY_W-1:0];
    endfunction

    assign rd_addr = {ci_reg, cj_reg, ck_reg};
    assign pij     = (wu[ci_reg[IW-1:0]] * wv[cj_reg[IW-1:0]]) + (2*WGT_W)'(1 << 29);
    assign pw      = (wij_reg * ww[kk1_reg[IW-1:0]]) + (2*WGT_W)'(1 << 29);
    assign drained = run_reg && !iss_reg && !v1_reg && !v2_reg && !v3_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            q_c[a] = finish(acc_reg[a], sat_c[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            iss_reg  <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            ci_reg   <= '0;
            cj_reg   <= '0;
            ck_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            v1_reg   <= iss_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            if (start)
            begin
                run_reg <= 1'b1;
                iss_reg <= 1'b1;
                ci_reg  <= '0;
                cj_reg  <= '0;
                ck_reg  <= '0;
            end
            else
            begin
                if (iss_reg)
                begin
                    // advance k fastest, then j, then i
                    if (ck_reg == deg.nw)
                    begin
                        ck_reg <= '0;
                        if (cj_reg == deg.nv)
                        begin
                            cj_reg <= '0;
                            if (ci_reg == deg.nu)
                            begin
                                iss_reg <= 1'b0;
                                ci_reg  <= '0;
                            end
                            else
                            begin
                                ci_reg <= ci_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            cj_reg <= cj_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ck_reg <= ck_reg + 2'd1;
                    end
                end
                if (drained)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wij_reg <= pij[2*WGT_W-2:30];
        kk1_reg <= ck_reg;
        w_reg   <= pw[2*WGT_W-2:30];
        for (int a = 0; a < 3; a++)
        begin
            c2_reg[a]   <= rd_data[a*EFF_W +: EFF_W];
            prod_reg[a] <= PW'($signed(c2_reg[a]) * $signed({1'b0, w_reg}));
            if (start)
            begin
                acc_reg[a] <= '0;
            end
            else if (v3_reg)
            begin
                acc_reg[a] <= acc_reg[a] + ACC_W'($signed(prod_reg[a]));
            end
        end
        if (drained && !start)
        begin
            res_reg <= q_c;
            sat_reg <= |sat_c;
        end
    end

    assign res     = res_reg;
    assign res_sat = sat_reg;
    assign done    = done_reg;

endmodule

FILE: hw/rtl/bezier_volume_point_eval.sv
// ----------------------------------------------------------------------------
// bezier_volume_point_eval
// Trivariate tensor-product Bezier volume evaluator, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tuser carries the opcode. A load transaction
//   writes one control point into slot i*16+j*4+k. An
//   evaluate transaction carries u, v, w in Q1.15 and yields one result
//   transaction on m_axis_*; loads yield none.
//   Configuration: cfg_we with cfg_addr 0/1/2 sets the degree along u/v/w.
//   Write only while the block is idle.
// Evaluate: the weight sequencer computes the n+1 weights of each axis of
//   degree n in turn, one multiply per factor and then a store; the term
//   loop then reads the control point memory once per term, for
//   (nu+1)(nv+1)(nw+1) terms, at most 64, then drains its pipeline and
//   rounds. The single memory read port sets the term loop rate.
// One item is in flight at a time; s_axis_tready is high in the idle state.
// The result sits in an output register, so the next item is taken while
//   the receiver stalls; a finished evaluate waits until that register frees.
// Reset clears control state and sets all degrees to 3. The control point
//   memory is not cleared: read only slots that were loaded.
// ----------------------------------------------------------------------------
module bezier_volume_point_eval #(
    parameter int MAX_DEGREE  = bvpe_pkg::MAX_DEGREE_DEF,
    parameter int COORD_WIDTH = bvpe_pkg::COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // fields from bit 0: point_index[5:0], coord_x, coord_y, coord_z,
    // param_u, param_v, param_w, 2 bits zero fill
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fields from bit 0: point_x, point_y, point_z
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tuser,   // saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [1:0]   cfg_wdata
);
    import bvpe_pkg::*;

    localparam int EFF_W = (COORD_WIDTH > XY_W) ? XY_W : COORD_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WGT  = 2'd1;
    localparam logic [1:0] ST_MAC  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    deg_t       deg_reg;
    deg_t       deg_eff;
    logic [2:0][PARAM_W-1:0] param_reg;

    logic        in_fire, ld_fire, ev_fire;
    logic        wgt_done, mac_done, out_load;
    logic        out_valid_reg;
    logic [95:0] out_data_reg;
    logic        out_sat_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [3*EFF_W-1:0] rd_data, wr_data;
    logic [MAX_DEGREE:0][WGT_W-1:0] wu, wv, ww;
    logic [2:0][XY_W-1:0] res;
    logic                 res_sat;

    function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] d);
        return (d > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : d;
    endfunction

    function automatic logic [PARAM_W-1:0] clamp_par(input logic [PARAM_W-1:0] p);
        return (p > ONE_Q15) ? ONE_Q15 : p;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign ld_fire       = in_fire && (s_axis_tuser == OP_LOAD);
    assign ev_fire       = in_fire && (s_axis_tuser == OP_EVAL);
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign deg_eff.nu = clamp_deg(deg_reg.nu);
    assign deg_eff.nv = clamp_deg(deg_reg.nv);
    assign deg_eff.nw = clamp_deg(deg_reg.nw);

    // truncate the coordinates to the stored width
    assign wr_data = {s_axis_tdata[70 +: EFF_W], s_axis_tdata[38 +: EFF_W],
                      s_axis_tdata[6 +: EFF_W]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ev_fire)
                begin
                    state_next = ST_WGT;
                end
            end
            ST_WGT:
            begin
                if (wgt_done)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deg_reg.nu    <= 2'd3;
            deg_reg.nv    <= 2'd3;
            deg_reg.nw    <= 2'd3;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_DEG_U: deg_reg.nu <= cfg_wdata;
                    REG_DEG_V: deg_reg.nv <= cfg_wdata;
                    REG_DEG_W: deg_reg.nw <= cfg_wdata;
                    default:   ;
                endcase
            end
            // hold the result until the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_fire)
        begin
            param_reg[0] <= clamp_par(s_axis_tdata[102 +: PARAM_W]);
            param_reg[1] <= clamp_par(s_axis_tdata[118 +: PARAM_W]);
            param_reg[2] <= clamp_par(s_axis_tdata[134 +: PARAM_W]);
        end
        if (out_load)
        begin
            out_data_reg <= {res[2], res[1], res[0]};
            out_sat_reg  <= res_sat;
        end
    end

    bvpe_store #(
        .EFF_W (EFF_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ld_fire),
        .wr_addr (s_axis_tdata[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bvpe_weight #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == ST_IDLE) && (state_next == ST_WGT)),
        .deg   (deg_eff),
        .param (param_reg),
        .wu    (wu),
        .wv    (wv),
        .ww    (ww),
        .done  (wgt_done)
    );

    bvpe_mac #(
        .MAX_DEGREE (MAX_DEGREE),
        .EFF_W      (EFF_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   ((state_reg == ST_WGT) && wgt_done),
        .deg     (deg_eff),
        .wu      (wu),
        .wv      (wv),
        .ww      (ww),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (res),
        .res_sat (res_sat),
        .done    (mac_done)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
